// File: rtl/positional_list_insert_remove_assert.svh
// Assertion macros for the positional list block.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PLI_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("positional list check failed");

`define PLI_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("positional list check failed");

`else

`define PLI_ASSERT_IMPLIES(label, clk, rst, lhs, rhs)

`define PLI_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

// File: rtl/pli_pkg.sv
package pli_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   typedef struct packed {
      logic                      action;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] entry_value;
      logic                      list_empty;
      logic                      last_entry;
      logic                      insert_dropped;
   } rsp_item_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_ROTATE
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type             mode;
      logic [CNT_W-1:0]          pos;
      logic [CNT_W-1:0]          wrap_idx;
      logic signed [VALUE_W-1:0] value;
   } cell_ctl_type;

endpackage

// File: rtl/pli_cell.sv
module pli_cell
   import pli_pkg::*;
(
   input  logic                      clock,
   input  logic [CNT_W-1:0]          cell_index,
   input  cell_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] prev_value,
   input  logic signed [VALUE_W-1:0] next_value,
   input  logic signed [VALUE_W-1:0] head_value,
   output logic signed [VALUE_W-1:0] entry_value
);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.mode)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_INSERT: begin
            if (cell_index == ctl.pos) begin
               entry_in = ctl.value;
            end else if (cell_index > ctl.pos) begin
               entry_in = prev_value;
            end
         end
         CELL_REMOVE: begin
            if (cell_index >= ctl.pos) begin
               entry_in = next_value;
            end
         end
         CELL_ROTATE: begin
            if (cell_index == ctl.wrap_idx) begin
               entry_in = head_value;
            end else begin
               entry_in = next_value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;

endmodule

// File: rtl/positional_list_insert_remove.sv
// Order: the list is updated at the edge that accepts an item; its first result is
// registered from the dump state once the output register is free.
// Flow: a new item is taken only when the whole list has been dumped, the cell chain
// rotating one entry to the head per cycle while the output is not stalled.
// Reset: synchronous, active high; clears the entry count, state and output valid.
// Entry cells are not cleared.
`include "positional_list_insert_remove_assert.svh"

module positional_list_insert_remove
   import pli_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] dump_idx_ff, dump_idx_in;
   logic             dropped_ff, dropped_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   cell_ctl_type              cell_ctl;
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic signed [VALUE_W-1:0] prev_value [CAPACITY];
   logic signed [VALUE_W-1:0] next_value [CAPACITY];

   logic             req_accept;
   logic             out_free;
   logic [POS_W-1:0] count_wide;
   logic [CNT_W-1:0] count_m1;
   logic [CNT_W-1:0] count_p1;
   logic             is_last;
   logic             insert_fits;
   logic             out_empty;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign count_wide = POS_W'(count_ff);
   assign count_m1   = count_ff - CNT_W'(1);
   assign count_p1   = count_ff + CNT_W'(1);
   assign is_last    = (count_ff == '0) || (dump_idx_ff == count_m1);

   assign insert_fits = req_accept && (req_item.action == ACT_INSERT) &&
                        (count_ff < CNT_W'(CAPACITY));
   assign out_empty   = rsp_valid_ff && rsp_item_ff.list_empty;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dump_idx_in  = dump_idx_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;

      cell_ctl.mode     = CELL_HOLD;
      cell_ctl.pos      = '0;
      cell_ctl.wrap_idx = count_m1;
      cell_ctl.value    = req_item.value;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in    = ST_DUMP;
               dump_idx_in = '0;
               dropped_in  = 1'b0;
               if (req_item.action == ACT_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     dropped_in = 1'b1;
                  end else begin
                     cell_ctl.mode = CELL_INSERT;
                     cell_ctl.pos  = (req_item.position > count_wide) ?
                                     count_ff : CNT_W'(req_item.position);
                     count_in      = count_p1;
                  end
               end else if (req_item.position < count_wide) begin
                  cell_ctl.mode = CELL_REMOVE;
                  cell_ctl.pos  = CNT_W'(req_item.position);
                  count_in      = count_m1;
               end
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_item_in.entry_value     = (count_ff == '0) ? '0 : cell_value[0];
               rsp_item_in.list_empty      = (count_ff == '0);
               rsp_item_in.last_entry      = is_last;
               rsp_item_in.insert_dropped  = dropped_ff;
               if (count_ff != '0) begin
                  cell_ctl.mode = CELL_ROTATE;
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  dump_idx_in = dump_idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dump_idx_ff <= dump_idx_in;
      dropped_ff  <= dropped_in;
      rsp_item_ff <= rsp_item_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_value[i] = cell_value[i];
      end else begin : g_prev
         assign prev_value[i] = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_final
         assign next_value[i] = cell_value[i];
      end else begin : g_next
         assign next_value[i] = cell_value[i+1];
      end

      pli_cell u_cell (
         .clock       (clock),
         .cell_index  (CNT_W'(i)),
         .ctl         (cell_ctl),
         .prev_value  (prev_value[i]),
         .next_value  (next_value[i]),
         .head_value  (cell_value[0]),
         .entry_value (cell_value[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `PLI_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `PLI_ASSERT_IMPLIES(a_dump_blocks_req, clock, reset, state_ff == ST_DUMP, req_stall)
   `PLI_ASSERT_NEXT(a_insert_grows, clock, reset, insert_fits, count_ff == $past(count_p1))
   `PLI_ASSERT_IMPLIES(a_empty_is_last, clock, reset, out_empty, rsp_item_ff.last_entry)

endmodule

// File: verif/positional_list_insert_remove_check.sv
module positional_list_insert_remove_check
   import pli_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_item,
   output int           failures,
   output int           pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [VALUE_W-1:0] list_store [CAPACITY];
   int unsigned               list_len;
   rsp_item_type              dump_q [$];

   task automatic report_error(input string msg);
      $display("%0t ERROR %s", $time, msg);
      failures++;
   endtask

   task automatic apply_list_op(input req_item_type op);
      int unsigned  slot;
      int unsigned  i;
      logic         dropped;
      rsp_item_type entry;
      dropped = 1'b0;
      if (op.action == ACT_INSERT) begin
         if (list_len >= CAPACITY) begin
            dropped = 1'b1;
         end else begin
            slot = (op.position > list_len) ? list_len : op.position;
            for (i = list_len; i > slot; i--) begin
               list_store[i] = list_store[i-1];
            end
            list_store[slot] = op.value;
            list_len++;
         end
      end else if (op.position < list_len) begin
         for (i = op.position; i + 1 < list_len; i++) begin
            list_store[i] = list_store[i+1];
         end
         list_len--;
      end
      if (list_len == 0) begin
         entry                = '0;
         entry.list_empty     = 1'b1;
         entry.last_entry     = 1'b1;
         entry.insert_dropped = dropped;
         dump_q.push_back(entry);
      end else begin
         for (i = 0; i < list_len; i++) begin
            entry.entry_value    = list_store[i];
            entry.list_empty     = 1'b0;
            entry.last_entry     = (i + 1 == list_len);
            entry.insert_dropped = dropped;
            dump_q.push_back(entry);
         end
      end
   endtask

   task automatic check_entry(input rsp_item_type got);
      rsp_item_type want;
      if (dump_q.size() == 0) begin
         report_error($sformatf("item with nothing expected: value %0d", got.entry_value));
      end else begin
         want = dump_q.pop_front();
         if (got.entry_value !== want.entry_value) begin
            report_error($sformatf("entry_value: expected %0d got %0d",
                                   want.entry_value, got.entry_value));
         end
         if (got.list_empty !== want.list_empty) begin
            report_error($sformatf("list_empty: expected %b got %b",
                                   want.list_empty, got.list_empty));
         end
         if (got.last_entry !== want.last_entry) begin
            report_error($sformatf("last_entry: expected %b got %b",
                                   want.last_entry, got.last_entry));
         end
         if (got.insert_dropped !== want.insert_dropped) begin
            report_error($sformatf("insert_dropped: expected %b got %b",
                                   want.insert_dropped, got.insert_dropped));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         failures = 0;
         dump_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_entry(rsp_item);
         end
         if (req_valid && !req_stall) begin
            apply_list_op(req_item);
         end
      end
      pending_results = dump_q.size();
   end

endmodule

// File: verif/positional_list_insert_remove_test.sv
module positional_list_insert_remove_test
   import pli_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 40;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_item_type req_item    = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_item_type rsp_item;
   int           failures;
   int           pending_results;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   logic         hold_toggle   = 1'b0;
   logic         hold_seen     = 1'b0;
   int           hold_left     = 0;
   int           quiet_cycles  = 0;

   positional_list_insert_remove u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   positional_list_insert_remove_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .failures        (failures),
      .pending_results (pending_results)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hold the result channel off for a long stretch on each toggle request
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_item_type make_op(input logic act, input int unsigned pos,
                                            input logic [VALUE_W-1:0] val);
      req_item_type op;
      op.action   = act;
      op.position = pos[POS_W-1:0];
      op.value    = val;
      return op;
   endfunction

   task automatic send_item(input req_item_type op);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= op;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random(input int insert_pct);
      logic                act;
      int unsigned         pos;
      logic [VALUE_W-1:0]  val;
      int unsigned         pick;
      act  = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
      pick = $urandom_range(99);
      if (pick < 75) begin
         pos = $urandom_range(0, 40);
      end else if (pick < 90) begin
         pos = $urandom_range(0, 255);
      end else begin
         pos = pick[0] ? 255 : 0;
      end
      case ($urandom_range(19))
         0:       val = 32'h8000_0000;
         1:       val = 32'h7FFF_FFFF;
         2:       val = 32'hFFFF_FFFF;
         3:       val = 32'h0000_0000;
         default: val = $urandom();
      endcase
      send_item(make_op(act, pos, val));
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
   endtask

   task automatic run_phase(input int s_pct, input int r_pct, input bit with_hold);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      // grow towards a full list, then shrink it again
      repeat (60) begin
         send_random(85);
         if (with_hold && pending_results > 0 && hold_left == 0 && hold_toggle == hold_seen) begin
            hold_toggle <= ~hold_toggle;
            with_hold = 1'b0;
         end
      end
      repeat (40) begin
         send_random(20);
      end
      wait_results_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(make_op(ACT_REMOVE, 0, 32'h0));
      send_item(make_op(ACT_REMOVE, 255, 32'h1234_5678));
      send_item(make_op(ACT_INSERT, 255, 32'h7FFF_FFFF));
      send_item(make_op(ACT_INSERT, 0, 32'h8000_0000));
      send_item(make_op(ACT_INSERT, 1, 32'hFFFF_FFFF));
      send_item(make_op(ACT_INSERT, 2, 32'h0000_0000));
      send_item(make_op(ACT_INSERT, 4, 32'h0000_0001));
      send_item(make_op(ACT_INSERT, 128, 32'h5555_5555));
      send_item(make_op(ACT_INSERT, 3, 32'hAAAA_AAAA));
      send_item(make_op(ACT_REMOVE, 7, 32'h0));
      send_item(make_op(ACT_REMOVE, 6, 32'h0));
      send_item(make_op(ACT_REMOVE, 0, 32'h0));
      send_item(make_op(ACT_REMOVE, 2, 32'hFFFF_FFFF));
      send_item(make_op(ACT_REMOVE, 255, 32'h0));
      send_item(make_op(ACT_REMOVE, 0, 32'h0));
      send_item(make_op(ACT_REMOVE, 0, 32'h0));
      send_item(make_op(ACT_REMOVE, 0, 32'h0));
      send_item(make_op(ACT_REMOVE, 0, 32'h0));
      wait_results_drained();

      run_phase(18, 54, 1'b1);
      run_phase(54, 18, 1'b0);
      run_phase(0, 0, 1'b0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && pending_results == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
